// ----- rtl/assert_macros.svh -----
// Assertion macros for the RTL of the epoch-to-date converter.
// No dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// expr must hold at every clock edge outside reset
`define ASSERT_ALWAYS(label, clk, rst, expr) \
   label: assert property (@(posedge clk) disable iff (rst) (expr)) \
      else $error("assertion failed: invariant");

// cons must hold at every clock edge at which ante holds, outside reset
`define ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed: implication");

`endif

// ----- rtl/ecd_pkg.sv -----
// Package of the epoch-to-date converter: types, constants and small functions.
// No dependencies.
`timescale 1ns / 1ps

package ecd_pkg;

   localparam int TOP_STAGES  = 4;
   localparam int DATE_STAGES = 9;
   localparam int TIME_STAGES = 3;
   // the first delay register is the last time stage
   localparam int TIME_DELAY  = DATE_STAGES - TIME_STAGES + 1;
   localparam int LATENCY     = TOP_STAGES + DATE_STAGES;

   // floor(2^35 / 675): seconds>>7 to days, estimate low by at most one
   localparam logic [25:0] DAY_RECIP      = 26'd50903316;
   localparam logic [16:0] SECS_PER_DAY   = 17'd86400;
   // ceil(2^23 / 60): exact for dividends below 2^17
   localparam logic [17:0] SIXTY_RECIP    = 18'd139811;
   // days from 0000-03-01 to 1970-01-01
   localparam logic [19:0] DAY_OFFSET     = 20'd719468;
   localparam logic [17:0] DAYS_PER_400Y  = 18'd146097;
   // floor(2^40 / 146097): year estimate low by at most one
   localparam logic [22:0] YEAR_RECIP     = 23'd7525901;
   // ceil(2^19 / 100): exact below 43699
   localparam logic [12:0] HUNDRED_RECIP  = 13'd5243;
   // 10 * ceil(2^20 / 306)
   localparam logic [15:0] MONTH_RECIP    = 16'd34270;
   localparam logic [8:0]  MARCH_JAN_START = 9'd306;

   typedef struct packed {
      logic [5:0] second;
      logic [5:0] minute;
      logic [4:0] hour;
      logic [2:0] weekday;
   } time_type;

   typedef struct packed {
      logic [11:0] year;
      logic [3:0]  month;
      logic [4:0]  day_of_month;
   } date_type;

   // x mod 7 by folding octal digits (8 = 1 mod 7)
   function automatic logic [2:0] mod7(input logic [16:0] x);
      logic [17:0] v;
      logic [5:0]  s;
      logic [3:0]  f;
      logic [2:0]  r;
      v = {1'b0, x};
      s = 6'd0;
      for (int i = 0; i < 6; i++) begin
         s = s + 6'(v[3*i +: 3]);
      end
      f = 4'(s[2:0]) + 4'(s[5:3]);
      if (f >= 4'd14) begin
         r = 3'(f - 4'd14);
      end else if (f >= 4'd7) begin
         r = 3'(f - 4'd7);
      end else begin
         r = f[2:0];
      end
      return r;
   endfunction

   // 367 * mon / 12 for March-based month index 0..12
   function automatic logic [8:0] cum_days(input logic [3:0] mon);
      logic [8:0] c;
      case (mon)
         4'd0:    c = 9'd0;
         4'd1:    c = 9'd30;
         4'd2:    c = 9'd61;
         4'd3:    c = 9'd91;
         4'd4:    c = 9'd122;
         4'd5:    c = 9'd152;
         4'd6:    c = 9'd183;
         4'd7:    c = 9'd214;
         4'd8:    c = 9'd244;
         4'd9:    c = 9'd275;
         4'd10:   c = 9'd305;
         4'd11:   c = 9'd336;
         4'd12:   c = 9'd367;
         default: c = 9'd0;
      endcase
      return c;
   endfunction

endpackage

// ----- rtl/ecd_date_pipe.sv -----
// Day count to year, month and day of month, nine register stages.
// Depends on ecd_pkg.
`timescale 1ns / 1ps

module ecd_date_pipe (
   input  logic              clock,
   input  logic              reset,
   input  logic              in_valid,
   input  logic [15:0]       in_days,
   output logic              out_valid,
   output ecd_pkg::date_type out_date
);
   import ecd_pkg::*;

   logic [DATE_STAGES-1:0] valid_ff;

   // stage 1: March-based day number and scaled dividend
   logic [19:0] d_e_ff, d_e_in;
   logic [28:0] n_e_ff, n_e_in;
   // stage 2: year estimate
   logic [19:0] d_f_ff;
   logic [28:0] n_f_ff;
   logic [11:0] yest_f_ff, yest_f_in;
   logic [51:0] yprod;
   // stage 3: back-multiply
   logic [19:0] d_g_ff;
   logic [28:0] n_g_ff;
   logic [11:0] yest_g_ff;
   logic [29:0] back_g_ff, back_g_in;
   // stage 4: corrected year
   logic [19:0] d_h_ff;
   logic [11:0] year_h_ff, year_h_in;
   logic [29:0] yrem;
   // stage 5: century terms
   logic [19:0] d_i_ff;
   logic [11:0] year_i_ff;
   logic [4:0]  q100_i_ff, q100_i_in;
   logic [2:0]  q400_i_ff, q400_i_in;
   logic [20:0] y365_i_ff, y365_i_in;
   logic [24:0] p100;
   logic [22:0] p400;
   // stage 6: day of year, leap flag
   logic [11:0] year_j_ff;
   logic [10:0] yd_j_ff, yd_j_in;
   logic        leap_j_ff, leap_j_in;
   logic [20:0] dby;
   logic signed [21:0] yd_full;
   logic [11:0] hund;
   // stage 7: overshoot correction
   logic [11:0] year_k_ff, year_k_in;
   logic [8:0]  yday_k_ff, yday_k_in;
   logic [10:0] yd_fix;
   // stage 8: month index
   logic [11:0] year_l_ff;
   logic [8:0]  yday_l_ff;
   logic [3:0]  mon_l_ff, mon_l_in;
   logic [24:0] mprod;
   // stage 9: output
   date_type    date_m_ff, date_m_in;
   logic [9:0]  mday_full;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= {valid_ff[DATE_STAGES-2:0], in_valid};
      end
   end

   always_comb begin
      d_e_in = 20'(in_days) + DAY_OFFSET;
      n_e_in = 29'(d_e_in + 20'd2) * 29'd400;
   end

   always_comb begin
      yprod     = 52'(n_e_ff) * 52'(YEAR_RECIP);
      yest_f_in = yprod[51:40];
   end

   always_comb begin
      back_g_in = 30'(yest_f_ff) * 30'(DAYS_PER_400Y);
   end

   always_comb begin
      yrem      = 30'(n_g_ff) - back_g_ff;
      year_h_in = (yrem >= 30'(DAYS_PER_400Y)) ? 12'(yest_g_ff + 12'd1) : yest_g_ff;
   end

   always_comb begin
      p100      = 25'(year_h_ff) * 25'(HUNDRED_RECIP);
      p400      = 23'(year_h_ff[11:2]) * 23'(HUNDRED_RECIP);
      q100_i_in = p100[23:19];
      q400_i_in = p400[21:19];
      y365_i_in = 21'(year_h_ff) * 21'd365;
   end

   always_comb begin
      dby       = y365_i_ff + 21'(year_i_ff[11:2]) - 21'(q100_i_ff) + 21'(q400_i_ff);
      yd_full   = $signed({2'b00, d_i_ff}) - $signed({1'b0, dby});
      yd_j_in   = yd_full[10:0];
      hund      = 12'(q100_i_ff) * 12'd100;
      leap_j_in = (year_i_ff[1:0] == 2'b00) &&
                  ((hund != year_i_ff) || (q100_i_ff[1:0] == 2'b00));
   end

   always_comb begin
      yd_fix = yd_j_ff + 11'd365 + 11'(leap_j_ff);
      if (yd_j_ff[10]) begin
         year_k_in = 12'(year_j_ff - 12'd1);
         yday_k_in = yd_fix[8:0];
      end else begin
         year_k_in = year_j_ff;
         yday_k_in = yd_j_ff[8:0];
      end
   end

   always_comb begin
      mprod    = (25'(yday_k_ff) + 25'd31) * 25'(MONTH_RECIP);
      mon_l_in = mprod[23:20];
   end

   always_comb begin
      mday_full              = 10'(yday_l_ff) + 10'd31 - 10'(cum_days(mon_l_ff));
      date_m_in.day_of_month = mday_full[4:0];
      if (yday_l_ff >= MARCH_JAN_START) begin
         date_m_in.year  = 12'(year_l_ff + 12'd1);
         date_m_in.month = 4'(mon_l_ff - 4'd10);
      end else begin
         date_m_in.year  = year_l_ff;
         date_m_in.month = 4'(mon_l_ff + 4'd2);
      end
   end

   always_ff @(posedge clock) begin
      d_e_ff    <= d_e_in;
      n_e_ff    <= n_e_in;
      d_f_ff    <= d_e_ff;
      n_f_ff    <= n_e_ff;
      yest_f_ff <= yest_f_in;
      d_g_ff    <= d_f_ff;
      n_g_ff    <= n_f_ff;
      yest_g_ff <= yest_f_ff;
      back_g_ff <= back_g_in;
      d_h_ff    <= d_g_ff;
      year_h_ff <= year_h_in;
      d_i_ff    <= d_h_ff;
      year_i_ff <= year_h_ff;
      q100_i_ff <= q100_i_in;
      q400_i_ff <= q400_i_in;
      y365_i_ff <= y365_i_in;
      year_j_ff <= year_i_ff;
      yd_j_ff   <= yd_j_in;
      leap_j_ff <= leap_j_in;
      year_k_ff <= year_k_in;
      yday_k_ff <= yday_k_in;
      year_l_ff <= year_k_ff;
      yday_l_ff <= yday_k_ff;
      mon_l_ff  <= mon_l_in;
      date_m_ff <= date_m_in;
   end

   assign out_valid = valid_ff[DATE_STAGES-1];
   assign out_date  = date_m_ff;

endmodule

// ----- rtl/epoch_seconds_to_civil_date_core.sv -----
// Top level of the epoch-seconds to civil date and time converter.
// Depends on ecd_pkg, ecd_date_pipe and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

// Usage:
//   Request channel: drive req_epoch_seconds and raise start; the request is
//   taken at a rising edge with start high and busy low. busy is high only
//   while reset is asserted, so a request can be issued in every cycle.
//   Result channel: rsp_strobe is high for exactly one cycle per request,
//   with second, minute, hour, day of month, month, year and weekday on the
//   rsp_ ports during that cycle. The receiver cannot stall; results leave
//   in request order.
//   Pipeline: a request passes 13 register stages (input register, three
//   for the division by 86400, nine for the date path) to the strobe.
//   Throughput: one request per cycle, set by the fully pipelined data
//   path, each stage holding only multiplies, adds and compares.
//   Reset: synchronous, active high; clears all valid bits, so requests in
//   flight are dropped and no strobe follows until new requests arrive.

module epoch_seconds_to_civil_date_core (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [31:0] req_epoch_seconds,
   output logic        rsp_strobe,
   output logic [5:0]  rsp_second,
   output logic [5:0]  rsp_minute,
   output logic [4:0]  rsp_hour,
   output logic [4:0]  rsp_day_of_month,
   output logic [3:0]  rsp_month,
   output logic [11:0] rsp_year,
   output logic [2:0]  rsp_weekday
);
   import ecd_pkg::*;

   logic        accept;
   logic [TOP_STAGES-1:0] valid_ff;

   logic [31:0] t_a_ff;
   logic [31:0] t_b_ff;
   logic [15:0] q_b_ff, q_b_in;
   logic [50:0] dprod;
   logic [31:0] t_c_ff;
   logic [15:0] q_c_ff;
   logic [31:0] back_c_ff, back_c_in;
   logic [31:0] drem;
   logic [15:0] days_d_ff, days_d_in;
   logic [16:0] tod_d_ff, tod_d_in;

   logic [34:0] tprod;
   logic [10:0] tmin_e_ff, tmin_e_in;
   logic [16:0] tod_e_ff;
   logic [2:0]  wday_e_ff, wday_e_in;
   logic [28:0] hprod;
   logic [16:0] sec_full;
   logic [10:0] tmin_f_ff;
   logic [5:0]  sec_f_ff, sec_f_in;
   logic [4:0]  hour_f_ff, hour_f_in;
   logic [2:0]  wday_f_ff;
   logic [10:0] min_full;
   time_type    time_g_in;
   time_type    time_dly_ff [TIME_DELAY];

   logic        date_valid;
   date_type    date_out;

   assign busy   = reset;
   assign accept = start && !busy;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= {valid_ff[TOP_STAGES-2:0], accept};
      end
   end

   // seconds / 86400 by reciprocal, then one correction step
   always_comb begin
      dprod  = 51'(t_a_ff[31:7]) * 51'(DAY_RECIP);
      q_b_in = dprod[50:35];
   end

   always_comb begin
      back_c_in = 32'(33'(q_b_ff) * 33'(SECS_PER_DAY));
   end

   always_comb begin
      drem = t_c_ff - back_c_ff;
      if (drem[17:0] >= 18'(SECS_PER_DAY)) begin
         days_d_in = 16'(q_c_ff + 16'd1);
         tod_d_in  = 17'(drem[17:0] - 18'(SECS_PER_DAY));
      end else begin
         days_d_in = q_c_ff;
         tod_d_in  = drem[16:0];
      end
   end

   // time of day and weekday
   always_comb begin
      tprod     = 35'(tod_d_ff) * 35'(SIXTY_RECIP);
      tmin_e_in = tprod[33:23];
      wday_e_in = mod7(17'(days_d_ff) + 17'd4);
   end

   always_comb begin
      sec_full  = tod_e_ff - 17'((17'(tmin_e_ff) << 6) - (17'(tmin_e_ff) << 2));
      sec_f_in  = sec_full[5:0];
      hprod     = 29'(tmin_e_ff) * 29'(SIXTY_RECIP);
      hour_f_in = hprod[27:23];
   end

   always_comb begin
      min_full          = tmin_f_ff - 11'((11'(hour_f_ff) << 6) - (11'(hour_f_ff) << 2));
      time_g_in.second  = sec_f_ff;
      time_g_in.minute  = min_full[5:0];
      time_g_in.hour    = hour_f_ff;
      time_g_in.weekday = wday_f_ff;
   end

   always_ff @(posedge clock) begin
      t_a_ff    <= req_epoch_seconds;
      t_b_ff    <= t_a_ff;
      q_b_ff    <= q_b_in;
      t_c_ff    <= t_b_ff;
      q_c_ff    <= q_b_ff;
      back_c_ff <= back_c_in;
      days_d_ff <= days_d_in;
      tod_d_ff  <= tod_d_in;
      tmin_e_ff <= tmin_e_in;
      tod_e_ff  <= tod_d_ff;
      wday_e_ff <= wday_e_in;
      tmin_f_ff <= tmin_e_ff;
      sec_f_ff  <= sec_f_in;
      hour_f_ff <= hour_f_in;
      wday_f_ff <= wday_e_ff;
      time_dly_ff[0] <= time_g_in;
      for (int i = 1; i < TIME_DELAY; i++) begin
         time_dly_ff[i] <= time_dly_ff[i-1];
      end
   end

   ecd_date_pipe u_date (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (valid_ff[TOP_STAGES-1]),
      .in_days   (days_d_ff),
      .out_valid (date_valid),
      .out_date  (date_out)
   );

   assign rsp_strobe       = date_valid;
   assign rsp_second       = time_dly_ff[TIME_DELAY-1].second;
   assign rsp_minute       = time_dly_ff[TIME_DELAY-1].minute;
   assign rsp_hour         = time_dly_ff[TIME_DELAY-1].hour;
   assign rsp_weekday      = time_dly_ff[TIME_DELAY-1].weekday;
   assign rsp_day_of_month = date_out.day_of_month;
   assign rsp_month        = date_out.month;
   assign rsp_year         = date_out.year;

   `ASSERT_IMPLY(a_strobe_latency, clock, reset, rsp_strobe, $past(accept, LATENCY))
   `ASSERT_IMPLY(a_date_range, clock, reset, rsp_strobe, (rsp_month >= 4'd1) && (rsp_month <= 4'd12) && (rsp_day_of_month >= 5'd1))
   `ASSERT_IMPLY(a_time_range, clock, reset, rsp_strobe, (rsp_hour <= 5'd23) && (rsp_minute <= 6'd59) && (rsp_second <= 6'd59) && (rsp_weekday <= 3'd6))
   `ASSERT_ALWAYS(a_busy_reset, clock, 1'b0, busy == reset)

endmodule

// ----- tb/sv/testbench.sv -----
// Self-checking testbench for epoch_seconds_to_civil_date_core: directed and random
// epoch values, predicted dates compared field by field with each result strobe.
// Depends on ecd_pkg and the core RTL.
`timescale 1ns / 1ps

module testbench;
   import ecd_pkg::*;

   localparam longint SECS_PER_DAY_L   = 86400;
   localparam longint SECS_PER_HOUR_L  = 3600;
   localparam longint EPOCH_MARCH_DAYS = 719527;
   localparam longint DAYS_IN_400Y     = 365 * 400 + 100 - 4 + 1;
   localparam longint JAN_START_YDAY   = 306;
   localparam longint MAX_EPOCH        = 64'hFFFF_FFFF;
   localparam int     CYCLE_LIMIT      = 200000;

   typedef struct {
      logic [31:0] epoch;
      logic [5:0]  second;
      logic [5:0]  minute;
      logic [4:0]  hour;
      logic [4:0]  day_of_month;
      logic [3:0]  month;
      logic [11:0] year;
      logic [2:0]  weekday;
   } civil_date_type;

   logic        clock = 1'b0;
   logic        reset;
   logic        start;
   logic        busy;
   logic [31:0] req_epoch_seconds;
   logic        rsp_strobe;
   logic [5:0]  rsp_second;
   logic [5:0]  rsp_minute;
   logic [4:0]  rsp_hour;
   logic [4:0]  rsp_day_of_month;
   logic [3:0]  rsp_month;
   logic [11:0] rsp_year;
   logic [2:0]  rsp_weekday;

   civil_date_type pending_dates[$];
   int          error_count = 0;
   int          cycle_count = 0;
   bit          idle_enable = 1'b1;

   epoch_seconds_to_civil_date_core dut (
      .clock             (clock),
      .reset             (reset),
      .start             (start),
      .busy              (busy),
      .req_epoch_seconds (req_epoch_seconds),
      .rsp_strobe        (rsp_strobe),
      .rsp_second        (rsp_second),
      .rsp_minute        (rsp_minute),
      .rsp_hour          (rsp_hour),
      .rsp_day_of_month  (rsp_day_of_month),
      .rsp_month         (rsp_month),
      .rsp_year          (rsp_year),
      .rsp_weekday       (rsp_weekday)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   function automatic bit leap_year(input longint y);
      return (y % 4 == 0) && ((y % 100 != 0) || (y % 400 == 0));
   endfunction

   // days from 0000-03-01 to March 1 of March-based year y
   function automatic longint days_before_march(input longint y);
      return 365 * y + y / 4 - y / 100 + y / 400;
   endfunction

   function automatic longint march_first_epoch(input longint y);
      return (days_before_march(y) - (EPOCH_MARCH_DAYS - 59)) * SECS_PER_DAY_L;
   endfunction

   function automatic civil_date_type convert_epoch(input logic [31:0] secs);
      longint      t;
      longint      days;
      longint      tod;
      longint      d;
      longint      yr;
      longint      yday;
      longint      mon;
      longint      mday;
      civil_date_type r;
      t    = longint'({32'd0, secs});
      days = t / SECS_PER_DAY_L;
      tod  = t % SECS_PER_DAY_L;
      r.epoch   = secs;
      r.weekday = 3'((4 + days) % 7);
      r.hour    = 5'(tod / SECS_PER_HOUR_L);
      r.minute  = 6'((tod % SECS_PER_HOUR_L) / 60);
      r.second  = 6'(tod % 60);
      d    = days - (31 + 28) + EPOCH_MARCH_DAYS;
      yr   = (d + 2) * 400 / DAYS_IN_400Y;
      yday = d - days_before_march(yr);
      // estimate one year too high
      if (yday < 0) begin
         yday = yday + (leap_year(yr) ? 366 : 365);
         yr   = yr - 1;
      end
      mon  = (yday + 31) * 10 / 306;
      mday = yday - (367 * mon / 12 - 30) + 1;
      if (yday >= JAN_START_YDAY) begin
         yr  = yr + 1;
         mon = mon - 10;
      end else begin
         mon = mon + 2;
      end
      r.day_of_month = 5'(mday);
      r.month        = 4'(mon);
      r.year         = 12'(yr);
      return r;
   endfunction

   task automatic report_mismatch(input string msg);
      $display("[%0t] mismatch: %s", $realtime, msg);
      error_count++;
   endtask

   task automatic check_field(input string name, input logic [11:0] got,
                              input logic [11:0] want, input logic [31:0] secs);
      if (got !== want) begin
         report_mismatch($sformatf("epoch %0d %s got %0d expected %0d",
                                   secs, name, got, want));
      end
   endtask

   always @(posedge clock) begin
      civil_date_type want;
      if (!reset && rsp_strobe) begin
         if (pending_dates.size() == 0) begin
            report_mismatch("result strobe with no request pending");
         end else begin
            want = pending_dates.pop_front();
            check_field("second", 12'(rsp_second), 12'(want.second), want.epoch);
            check_field("minute", 12'(rsp_minute), 12'(want.minute), want.epoch);
            check_field("hour", 12'(rsp_hour), 12'(want.hour), want.epoch);
            check_field("day_of_month", 12'(rsp_day_of_month),
                        12'(want.day_of_month), want.epoch);
            check_field("month", 12'(rsp_month), 12'(want.month), want.epoch);
            check_field("year", rsp_year, want.year, want.epoch);
            check_field("weekday", 12'(rsp_weekday), 12'(want.weekday), want.epoch);
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("testbench: done, errors");
         $finish;
      end
   end

   task automatic send_request(input logic [31:0] secs);
      start             <= 1'b1;
      req_epoch_seconds <= secs;
      do @(posedge clock); while (busy);
      pending_dates.push_back(convert_epoch(secs));
   endtask

   task automatic maybe_idle();
      if (idle_enable && $urandom_range(0, 3) == 0) begin
         start <= 1'b0;
         repeat ($urandom_range(1, 9)) @(posedge clock);
      end
   endtask

   task automatic drain_pending();
      start <= 1'b0;
      while (pending_dates.size() != 0) @(posedge clock);
   endtask

   task automatic test_time_fields();
      logic [31:0] vals[$] = '{32'd0, 32'd1, 32'd59, 32'd60, 32'd3599, 32'd3600,
                               32'd86399, 32'd86400, 32'h7FFF_FFFF, 32'h8000_0000,
                               32'hFFFF_FFFE, 32'hFFFF_FFFF};
      foreach (vals[i]) begin
         send_request(vals[i]);
         maybe_idle();
      end
   endtask

   task automatic test_calendar_edges();
      // month ends, leap days, 2000 leap, 2100 not leap, last full year
      logic [31:0] vals[$] = '{32'd2678399, 32'd2678400, 32'd5097599, 32'd5097600,
                               32'd31535999, 32'd31536000, 32'd68169600, 32'd68256000,
                               32'd946684799, 32'd951782400, 32'd951868800,
                               32'd4107499200, 32'd4107542400, 32'd4291747199};
      foreach (vals[i]) begin
         send_request(vals[i]);
         maybe_idle();
      end
   endtask

   task automatic test_random_spread(input int n);
      repeat (n) begin
         send_request($urandom);
         maybe_idle();
      end
   endtask

   // random instants around January 1 and March 1, where the year estimate slips
   task automatic test_year_turnover(input int n);
      longint y;
      longint secs;
      repeat (n) begin
         y = $urandom_range(1970, 2106);
         secs = march_first_epoch(y);
         if ($urandom_range(0, 1) == 1) begin
            secs = march_first_epoch(y - 1) + JAN_START_YDAY * SECS_PER_DAY_L;
         end
         secs = secs - $urandom_range(0, 1) * SECS_PER_DAY_L + $urandom_range(0, 86399);
         if (secs < 0) begin
            secs = 0;
         end else if (secs > MAX_EPOCH) begin
            secs = MAX_EPOCH - $urandom_range(0, 86399);
         end
         send_request(32'(secs));
         maybe_idle();
      end
   endtask

   task automatic test_back_to_back(input int n);
      idle_enable = 1'b0;
      repeat (n) begin
         if ($urandom_range(0, 1) == 1) begin
            send_request($urandom);
         end else begin
            send_request(32'($urandom_range(0, 49709)) * 32'd86400
                         + 32'($urandom_range(0, 86399)));
         end
      end
   endtask

   initial begin
      reset             <= 1'b1;
      start             <= 1'b0;
      req_epoch_seconds <= 32'd0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_time_fields();
      test_calendar_edges();
      drain_pending();
      test_random_spread(200);
      test_year_turnover(200);
      drain_pending();
      test_back_to_back(130);

      drain_pending();
      repeat (LATENCY + 8) @(posedge clock);
      if (error_count == 0) begin
         $display("testbench: done, clean");
      end else begin
         $display("testbench: done, errors");
      end
      $finish;
   end

endmodule
